// ===== src/hhd_pkg.sv =====
// ----------------------------------------------------------------------------
// hhd_pkg: shared definitions for the heartbeat hysteresis detector
// Field widths, configuration register indexes, reset values and divider size.
// ----------------------------------------------------------------------------
`default_nettype none

package hhd_pkg;

    // Channel field widths (fixed by the item format)
    localparam int SAMPLE_W   = 12;
    localparam int TIME_W     = 32;
    localparam int AVG_W      = 12;
    localparam int RATE_W     = 16;
    localparam int MINMAX_W   = 12;

    // Configuration port
    localparam int THRESH_W   = 12;
    localparam int REFR_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_REARM_LEVEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_MS = 2'd2;

    localparam logic [THRESH_W-1:0] REARM_LEVEL_RST   = 12'd2200;
    localparam logic [THRESH_W-1:0] TRIGGER_LEVEL_RST = 12'd1000;
    localparam logic [REFR_W-1:0]   REFRACTORY_MS_RST = 16'd300;

    // Serial divider: one quotient bit per cycle
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [DIV_W-1:0]  RATE_NUMERATOR = 32'd60000;
    localparam logic [RATE_W-1:0] RATE_SATURATED = 16'd60000;

    // Defaults for the top-level parameters
    localparam int WINDOW_LENGTH_DEF = 50;
    localparam int SAMPLE_BITS_DEF   = 12;

endpackage : hhd_pkg

`default_nettype wire

// ===== src/hhd_sample_if.sv =====
// ----------------------------------------------------------------------------
// hhd_sample_if: input channel of the heartbeat hysteresis detector
// Valid/ready channel carrying one converter sample and its timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface hhd_sample_if
    import hhd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   time_ms;

    modport source (output valid, output sample, output time_ms, input ready);
    modport sink   (input valid, input sample, input time_ms, output ready);
endinterface : hhd_sample_if

`default_nettype wire

// ===== src/hhd_result_if.sv =====
// ----------------------------------------------------------------------------
// hhd_result_if: result channel of the heartbeat hysteresis detector
// Valid/ready channel carrying average, beat flag, rate and window extremes.
// ----------------------------------------------------------------------------
`default_nettype none

interface hhd_result_if
    import hhd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                average_ready;
    logic [AVG_W-1:0]    window_average;
    logic                beat;
    logic [RATE_W-1:0]   beats_per_minute;
    logic [MINMAX_W-1:0] window_min;
    logic [MINMAX_W-1:0] window_max;

    modport source (
        output valid, output average_ready, output window_average, output beat,
        output beats_per_minute, output window_min, output window_max,
        input ready
    );
    modport sink (
        input valid, input average_ready, input window_average, input beat,
        input beats_per_minute, input window_min, input window_max,
        output ready
    );
endinterface : hhd_result_if

`default_nettype wire

// ===== src/heartbeat_hysteresis_detector.sv =====
// ----------------------------------------------------------------------------
// heartbeat_hysteresis_detector: windowed-average beat detector
// Circular sample window, hysteresis beat detection with refractory time and
// beats-per-minute from a serial divider.
// ----------------------------------------------------------------------------
// Each beat on sample_ch writes one sample into a circular window of
// WINDOW_LENGTH entries and produces exactly one beat on result_ch. The block
// works on one item at a time: after accepting a sample it scans the window
// through the store's single registered read port, one entry per cycle, to
// form the sum, minimum and maximum. The item that completes a window also
// forms the average in the last scan cycle by multiplying the sum with a
// fixed reciprocal of WINDOW_LENGTH and decides on the beat in ST_DECIDE;
// on a beat after the first with a nonzero interval it runs the 32-step
// serial divider for 60000 / interval, while a zero interval saturates the
// rate. A result waiting on result_ch does not block the next accept; only a
// second finished result waits for it. The window store resets to all zero
// through per-entry valid bits, so there is no clearing pass after reset.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once and
// belong in idle time; writes to unused indexes are ignored. The detector
// arms after reset, registers a beat when the average drops below the trigger
// level while armed and the refractory time has elapsed, and re-arms when the
// average climbs above the re-arm level.
// ----------------------------------------------------------------------------
`default_nettype none

module heartbeat_hysteresis_detector
    import hhd_pkg::*;
#(
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    hhd_sample_if.sink                 sample_ch,
    hhd_result_if.source               result_ch
);

    localparam int IDX_W  = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int SCAN_W = $clog2(WINDOW_LENGTH + 1);
    localparam int SUM_W  = SAMPLE_BITS + IDX_W;

    // Reciprocal of WINDOW_LENGTH, exact for every sum below 2**SUM_W
    localparam int RECIP_W   = SUM_W + 1;
    localparam int AVG_SHIFT = SUM_W + IDX_W;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

    // Sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_DECIDE   = 3'd3;
    localparam logic [2:0] ST_RATE_DIV = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [2:0]               state_reg, state_next;
    logic [IDX_W-1:0]         wp_reg, wp_next;
    logic [WINDOW_LENGTH-1:0] vld_reg, vld_next;
    logic                     wrap_reg, wrap_next;
    logic [SCAN_W-1:0]        scan_reg, scan_next;
    logic                     acc_reg, acc_next;
    logic [DIV_CNT_W-1:0]     cnt_reg, cnt_next;

    logic [THRESH_W-1:0]      hi_thr_reg, hi_thr_next;
    logic [THRESH_W-1:0]      lo_thr_reg, lo_thr_next;
    logic [REFR_W-1:0]        refr_reg, refr_next;

    logic [SAMPLE_BITS-1:0]   last_avg_reg, last_avg_next;
    logic [TIME_W-1:0]        last_beat_reg, last_beat_next;
    logic [RATE_W-1:0]        rate_reg, rate_next;
    logic                     rate_valid_reg, rate_valid_next;
    logic                     latched_reg, latched_next;
    logic                     beat_reg, beat_next;
    logic                     out_valid_reg, out_valid_next;

    // Payload registers (no reset)
    logic [TIME_W-1:0]        time_reg, time_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0]   min_reg, min_next;
    logic [SAMPLE_BITS-1:0]   max_reg, max_next;
    logic [DIV_W-1:0]         rem_reg, rem_next;
    logic [DIV_W-1:0]         quo_reg, quo_next;
    logic [DIV_W-1:0]         dvs_reg, dvs_next;
    logic                     o_avg_rdy_reg, o_avg_rdy_next;
    logic [AVG_W-1:0]         o_avg_reg, o_avg_next;
    logic                     o_beat_reg, o_beat_next;
    logic [RATE_W-1:0]        o_bpm_reg, o_bpm_next;
    logic [MINMAX_W-1:0]      o_min_reg, o_min_next;
    logic [MINMAX_W-1:0]      o_max_reg, o_max_next;

    // Window store with its registered read port
    logic [SAMPLE_BITS-1:0]   store_mem [WINDOW_LENGTH];
    logic [SAMPLE_BITS-1:0]   rd_data_reg;
    logic                     rd_vld_reg;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic                     in_acc;
    logic                     issue;
    logic [IDX_W-1:0]         scan_idx;
    logic [SAMPLE_BITS-1:0]   smp_w;
    logic [SAMPLE_BITS-1:0]   entry;
    logic                     wp_last;
    logic [PROD_W-1:0]        avg_prod;
    logic [SAMPLE_BITS-1:0]   avg_quo;
    logic [DIV_W:0]           rem_sh;
    logic                     div_ge;
    logic [DIV_W-1:0]         div_rem;
    logic [DIV_W-1:0]         div_quo;
    logic                     div_last;
    logic [TIME_W-1:0]        elapsed;
    logic                     beat_ok;
    logic                     out_free;

    assign in_acc   = sample_ch.valid && sample_ch.ready;
    assign issue    = (state_reg == ST_SCAN) && (scan_reg < SCAN_W'(WINDOW_LENGTH));
    assign scan_idx = scan_reg[IDX_W-1:0];
    assign smp_w    = SAMPLE_BITS'(sample_ch.sample);
    assign entry    = rd_vld_reg ? rd_data_reg : '0;
    assign wp_last  = (wp_reg == IDX_W'(WINDOW_LENGTH - 1));
    assign out_free = !out_valid_reg || result_ch.ready;

    // Window average: sum times reciprocal, 18 x 19 bits at the default
    assign avg_prod = PROD_W'(sum_reg) * PROD_W'(AVG_RECIP);
    assign avg_quo  = avg_prod[AVG_SHIFT +: SAMPLE_BITS];

    // One restoring-division step: shift in the next dividend bit, subtract
    assign rem_sh   = {rem_reg, quo_reg[DIV_W-1]};
    assign div_ge   = rem_sh >= {1'b0, dvs_reg};
    assign div_rem  = div_ge ? DIV_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DIV_W-1:0];
    assign div_quo  = {quo_reg[DIV_W-2:0], div_ge};
    assign div_last = (cnt_reg == DIV_CNT_W'(DIV_W - 1));

    // Beat decision on the freshly computed average
    assign elapsed  = time_reg - last_beat_reg;
    assign beat_ok  = (DIV_W'(last_avg_reg) < DIV_W'(lo_thr_reg)) && !latched_reg
                      && (elapsed >= TIME_W'(refr_reg));

    assign sample_ch.ready            = (state_reg == ST_IDLE);
    assign result_ch.valid            = out_valid_reg;
    assign result_ch.average_ready    = o_avg_rdy_reg;
    assign result_ch.window_average   = o_avg_reg;
    assign result_ch.beat             = o_beat_reg;
    assign result_ch.beats_per_minute = o_bpm_reg;
    assign result_ch.window_min       = o_min_reg;
    assign result_ch.window_max       = o_max_reg;

    // ------------------------------------------------------------------
    // Sequencer and datapath next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        vld_next        = vld_reg;
        wrap_next       = wrap_reg;
        scan_next       = scan_reg;
        acc_next        = issue;
        cnt_next        = cnt_reg;
        hi_thr_next     = hi_thr_reg;
        lo_thr_next     = lo_thr_reg;
        refr_next       = refr_reg;
        last_avg_next   = last_avg_reg;
        last_beat_next  = last_beat_reg;
        rate_next       = rate_reg;
        rate_valid_next = rate_valid_reg;
        latched_next    = latched_reg;
        beat_next       = beat_reg;
        out_valid_next  = out_valid_reg;
        time_next       = time_reg;
        sum_next        = sum_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        dvs_next        = dvs_reg;
        o_avg_rdy_next  = o_avg_rdy_reg;
        o_avg_next      = o_avg_reg;
        o_beat_next     = o_beat_reg;
        o_bpm_next      = o_bpm_reg;
        o_min_next      = o_min_reg;
        o_max_next      = o_max_reg;

        // Drop the result once the sink takes it
        if (out_valid_reg && result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_REARM_LEVEL:   hi_thr_next = cfg_data[THRESH_W-1:0];
                CFG_TRIGGER_LEVEL: lo_thr_next = cfg_data[THRESH_W-1:0];
                CFG_REFRACTORY_MS: refr_next   = cfg_data[REFR_W-1:0];
                default:           ;
            endcase
        end

        // Fold the entry read last cycle into sum, min and max
        if (acc_reg)
        begin
            sum_next = sum_reg + SUM_W'(entry);
            if (entry < min_reg)
            begin
                min_next = entry;
            end
            if (entry > max_reg)
            begin
                max_next = entry;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    vld_next[wp_reg] = 1'b1;
                    wp_next          = wp_last ? '0 : wp_reg + IDX_W'(1);
                    wrap_next        = wp_last;
                    time_next        = sample_ch.time_ms;
                    beat_next        = 1'b0;
                    scan_next        = '0;
                    sum_next         = '0;
                    min_next         = '1;
                    max_next         = '0;
                    state_next       = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (issue)
                begin
                    scan_next = scan_reg + SCAN_W'(1);
                end
                else if (!acc_reg)
                begin
                    if (wrap_reg)
                    begin
                        // Sum is complete: take the average from the reciprocal
                        last_avg_next = avg_quo;
                        state_next    = ST_DECIDE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DECIDE:
            begin
                state_next = ST_DONE;
                if (beat_ok)
                begin
                    rate_valid_next = 1'b1;
                    last_beat_next  = time_reg;
                    latched_next    = 1'b1;
                    beat_next       = 1'b1;
                    if (rate_valid_reg)
                    begin
                        if (elapsed == '0)
                        begin
                            rate_next = RATE_SATURATED;
                        end
                        else
                        begin
                            rem_next   = '0;
                            quo_next   = RATE_NUMERATOR;
                            dvs_next   = elapsed;
                            cnt_next   = '0;
                            state_next = ST_RATE_DIV;
                        end
                    end
                end
                // Re-arm check follows the beat check on the same average
                if (DIV_W'(last_avg_reg) > DIV_W'(hi_thr_reg))
                begin
                    latched_next = 1'b0;
                end
            end

            ST_RATE_DIV:
            begin
                rem_next = div_rem;
                quo_next = div_quo;
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (div_last)
                begin
                    rate_next  = RATE_W'(div_quo);
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_avg_rdy_next = wrap_reg;
                    o_avg_next     = AVG_W'(last_avg_reg);
                    o_beat_next    = beat_reg;
                    o_bpm_next     = rate_reg;
                    o_min_next     = MINMAX_W'(min_reg);
                    o_max_next     = MINMAX_W'(max_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            vld_reg        <= '0;
            wrap_reg       <= 1'b0;
            scan_reg       <= '0;
            acc_reg        <= 1'b0;
            cnt_reg        <= '0;
            hi_thr_reg     <= REARM_LEVEL_RST;
            lo_thr_reg     <= TRIGGER_LEVEL_RST;
            refr_reg       <= REFRACTORY_MS_RST;
            last_avg_reg   <= '0;
            last_beat_reg  <= '0;
            rate_reg       <= '0;
            rate_valid_reg <= 1'b0;
            latched_reg    <= 1'b0;
            beat_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            vld_reg        <= vld_next;
            wrap_reg       <= wrap_next;
            scan_reg       <= scan_next;
            acc_reg        <= acc_next;
            cnt_reg        <= cnt_next;
            hi_thr_reg     <= hi_thr_next;
            lo_thr_reg     <= lo_thr_next;
            refr_reg       <= refr_next;
            last_avg_reg   <= last_avg_next;
            last_beat_reg  <= last_beat_next;
            rate_reg       <= rate_next;
            rate_valid_reg <= rate_valid_next;
            latched_reg    <= latched_next;
            beat_reg       <= beat_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        time_reg      <= time_next;
        sum_reg       <= sum_next;
        min_reg       <= min_next;
        max_reg       <= max_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        dvs_reg       <= dvs_next;
        o_avg_rdy_reg <= o_avg_rdy_next;
        o_avg_reg     <= o_avg_next;
        o_beat_reg    <= o_beat_next;
        o_bpm_reg     <= o_bpm_next;
        o_min_reg     <= o_min_next;
        o_max_reg     <= o_max_next;
    end

    // ------------------------------------------------------------------
    // Window store: write on accept, one registered read per scan cycle
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            store_mem[wp_reg] <= smp_w;
        end
        if (issue)
        begin
            rd_data_reg <= store_mem[scan_idx];
            rd_vld_reg  <= vld_reg[scan_idx];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_one_item_at_a_time: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_acc |=> !sample_ch.ready
    ) else $error("sample accepted while an item is in progress");

    a_beat_needs_average: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_ch.valid && result_ch.beat |-> result_ch.average_ready
    ) else $error("beat reported without a completed window");

    a_wp_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        wp_reg < IDX_W'(WINDOW_LENGTH - 1) || wp_reg == IDX_W'(WINDOW_LENGTH - 1)
    ) else $error("write position beyond window");

    a_rate_after_beat: assert property (
        @(posedge clk) disable iff (!rst_n)
        rate_reg != '0 |-> rate_valid_reg
    ) else $error("rate set before any beat");

    a_result_not_overwritten: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_ch.ready |=> out_valid_reg && $stable(o_bpm_reg)
    ) else $error("pending result dropped or changed");

endmodule : heartbeat_hysteresis_detector

`default_nettype wire

// ===== bench/tb_heartbeat_hysteresis_detector.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_heartbeat_hysteresis_detector: self-checking bench for the beat detector
// Drives samples through the valid/ready channels under random back-pressure,
// predicts every result from a behavioral copy of the window, hysteresis and
// rate logic, and compares each result beat field by field.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic                           average_ready;
    logic [hhd_pkg::AVG_W-1:0]      window_average;
    logic                           beat;
    logic [hhd_pkg::RATE_W-1:0]     beats_per_minute;
    logic [hhd_pkg::MINMAX_W-1:0]   window_min;
    logic [hhd_pkg::MINMAX_W-1:0]   window_max;
} beat_reading_t;

class beat_scoreboard_t;
    logic [hhd_pkg::THRESH_W-1:0] high_thr;
    logic [hhd_pkg::THRESH_W-1:0] low_thr;
    logic [hhd_pkg::REFR_W-1:0]   refractory;

    logic [hhd_pkg::SAMPLE_W-1:0] window [hhd_pkg::WINDOW_LENGTH_DEF];
    int unsigned                  wr_pos;
    logic [hhd_pkg::TIME_W-1:0]   last_beat_ms;
    logic [hhd_pkg::RATE_W-1:0]   rate_bpm;
    logic                         latched;
    logic [hhd_pkg::AVG_W-1:0]    last_avg;
    logic                         rate_seen;

    beat_reading_t                awaited_readings [$];
    int                           errors;
    int unsigned                  checked;

    function new();
        high_thr     = hhd_pkg::REARM_LEVEL_RST;
        low_thr      = hhd_pkg::TRIGGER_LEVEL_RST;
        refractory   = hhd_pkg::REFRACTORY_MS_RST;
        foreach (window[i])
            window[i] = '0;
        wr_pos       = 0;
        last_beat_ms = '0;
        rate_bpm     = '0;
        latched      = 1'b0;
        last_avg     = '0;
        rate_seen    = 1'b0;
        errors       = 0;
        checked      = 0;
    endfunction

    function void write_register(logic [hhd_pkg::CFG_IDX_W-1:0] idx,
                                 logic [hhd_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            hhd_pkg::CFG_REARM_LEVEL:   high_thr = data[hhd_pkg::THRESH_W-1:0];
            hhd_pkg::CFG_TRIGGER_LEVEL: low_thr = data[hhd_pkg::THRESH_W-1:0];
            hhd_pkg::CFG_REFRACTORY_MS: refractory = data[hhd_pkg::REFR_W-1:0];
            default: ;
        endcase
    endfunction

    // Store the sample, run the window/hysteresis step and queue the reading.
    function void note_sample(logic [hhd_pkg::SAMPLE_W-1:0] smp,
                              logic [hhd_pkg::TIME_W-1:0] now);
        beat_reading_t              want;
        int unsigned                sum;
        logic [hhd_pkg::TIME_W-1:0] elapsed;
        logic [hhd_pkg::AVG_W-1:0]  avg;
        want = '0;
        window[wr_pos] = smp;
        wr_pos = (wr_pos + 1 >= hhd_pkg::WINDOW_LENGTH_DEF) ? 0 : wr_pos + 1;
        if (wr_pos == 0)
        begin
            sum = 0;
            foreach (window[i])
                sum += 32'(window[i]);
            avg = hhd_pkg::AVG_W'(sum / hhd_pkg::WINDOW_LENGTH_DEF);
            elapsed = now - last_beat_ms;
            want.average_ready = 1'b1;
            last_avg = avg;
            if (avg < low_thr && !latched && elapsed >= hhd_pkg::TIME_W'(refractory))
            begin
                if (rate_seen)
                    rate_bpm = (elapsed == 0) ? hhd_pkg::RATE_SATURATED
                             : hhd_pkg::RATE_W'(hhd_pkg::RATE_NUMERATOR / elapsed);
                rate_seen    = 1'b1;
                last_beat_ms = now;
                latched      = 1'b1;
                want.beat    = 1'b1;
            end
            // re-arm check follows the beat check on the same average
            if (avg > high_thr)
                latched = 1'b0;
        end
        want.window_average   = last_avg;
        want.beats_per_minute = rate_bpm;
        want.window_min       = window[0];
        want.window_max       = window[0];
        foreach (window[i])
        begin
            if (window[i] < want.window_min)
                want.window_min = window[i];
            if (window[i] > want.window_max)
                want.window_max = window[i];
        end
        awaited_readings.push_back(want);
    endfunction

    function int outstanding();
        return awaited_readings.size();
    endfunction

    task report_mismatch(string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("reading %0d: %s is %0d, expected %0d",
                                      checked, name, got, want));
    endtask

    task check_reading(beat_reading_t got);
        beat_reading_t want;
        if (awaited_readings.size() == 0)
        begin
            report_mismatch($sformatf("reading %0d arrived with nothing pending", checked));
        end
        else
        begin
            want = awaited_readings.pop_front();
            compare_field("average_ready", 32'(got.average_ready),
                          32'(want.average_ready));
            compare_field("window_average", 32'(got.window_average),
                          32'(want.window_average));
            compare_field("beat", 32'(got.beat), 32'(want.beat));
            compare_field("beats_per_minute", 32'(got.beats_per_minute),
                          32'(want.beats_per_minute));
            compare_field("window_min", 32'(got.window_min), 32'(want.window_min));
            compare_field("window_max", 32'(got.window_max), 32'(want.window_max));
        end
        checked++;
    endtask
endclass

module tb_heartbeat_hysteresis_detector;
    import hhd_pkg::*;

    localparam int WIN_LEN          = WINDOW_LENGTH_DEF;
    localparam int PHASES           = 9;
    localparam int CORNER_COUNT     = 25;
    // Leave margin after the last result for the tail of the block.
    localparam int DRAIN_CYCLES     = 130;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT      = 1_000_000;

    // Index 3 is not decoded by the block; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef enum int {WIN_LOW, WIN_HIGH, WIN_FULL, WIN_FLAT} window_shape_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hhd_sample_if sample_ch ();
    hhd_result_if result_ch ();

    heartbeat_hysteresis_detector u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_ch (sample_ch),
        .result_ch (result_ch)
    );

    beat_scoreboard_t  sb;
    int unsigned       send_idle_pct = 29;
    int unsigned       recv_idle_pct = 79;
    bit                long_hold_req = 1'b0;
    int unsigned       cycle_count   = 0;
    int unsigned       item_no       = 0;
    // Start 49 ms before zero so the first window closes exactly at time 0
    // and the timestamp wraps on the way there.
    logic [TIME_W-1:0] now_ms        = 32'hFFFF_FFCF;

    int windows_per_phase [PHASES] = '{5, 4, 4, 4, 5, 4, 4, 4, 5};

    // Sample extremes and bit patterns for the opening items.
    logic [SAMPLE_W-1:0] corner_samples [CORNER_COUNT] = '{
        12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h001, 12'h800, 12'hFFE, 12'h7FF,
        12'h000, 12'hFFF, 12'h0F0, 12'hF0F, 12'h3C3, 12'hC3C, 12'h001, 12'hFFF,
        12'h000, 12'h123, 12'hEDC, 12'h800, 12'h7FF, 12'hFFF, 12'h000, 12'hFFF,
        12'h000
    };

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Abort a hung run; the limit is several times the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: check every accepted result beat, then decide ready
    // for the next edge. A pending long hold overrides the random stalls.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned   hold_left;
        beat_reading_t got;
        hold_left       = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got.average_ready    = result_ch.average_ready;
                got.window_average   = result_ch.window_average;
                got.beat             = result_ch.beat;
                got.beats_per_minute = result_ch.beats_per_minute;
                got.window_min       = result_ch.window_min;
                got.window_max       = result_ch.window_max;
                sb.check_reading(got);
            end
            if (long_hold_req && hold_left == 0)
            begin
                hold_left     = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    // Write one register; the caller drops cfg_we after its last write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_register(idx, data);
    endtask

    // Pick the register set for a phase. The first three phases pin the
    // extremes and the reset values; the rest are random.
    task automatic configure_phase(input int phase);
        logic [THRESH_W-1:0] hi_thr;
        logic [THRESH_W-1:0] lo_thr;
        logic [REFR_W-1:0]   refr;
        case (phase)
            0:
            begin
                // crossed thresholds and no refractory time: beat on every
                // armed window, zero intervals possible
                hi_thr = 12'd0;
                lo_thr = 12'd4095;
                refr   = 16'd0;
            end
            1:
            begin
                // nothing can register or re-arm
                hi_thr = 12'd4095;
                lo_thr = 12'd0;
                refr   = 16'hFFFF;
            end
            2:
            begin
                hi_thr = REARM_LEVEL_RST;
                lo_thr = TRIGGER_LEVEL_RST;
                refr   = REFRACTORY_MS_RST;
            end
            default:
            begin
                lo_thr = THRESH_W'($urandom_range(2500, 300));
                hi_thr = THRESH_W'($urandom_range(3800, lo_thr));
                case ($urandom_range(3, 0))
                    0:       refr = 16'd1;
                    3:       refr = REFR_W'($urandom_range(65535, 1));
                    default: refr = REFR_W'($urandom_range(600, 1));
                endcase
            end
        endcase
        // upper data bits above a threshold are don't-care; toggle them
        write_register(CFG_REARM_LEVEL, {4'($urandom), hi_thr});
        write_register(CFG_TRIGGER_LEVEL, {4'($urandom), lo_thr});
        write_register(CFG_REFRACTORY_MS, refr);
        if (phase == 2)
            write_register(CFG_UNUSED_INDEX, 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Offer one sample beat after a random gap; return at the accepting edge.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic [TIME_W-1:0] t);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.sample  <= smp;
        sample_ch.time_ms <= t;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        sb.note_sample(smp, t);
    endtask

    // Send one full window of samples shaped around the live thresholds,
    // with a per-window timestamp step.
    task automatic send_window(input window_shape_t shape, input int phase);
        int unsigned         step_lo;
        int unsigned         step_hi;
        logic [SAMPLE_W-1:0] flat_level;
        logic [SAMPLE_W-1:0] smp;
        int                  k;
        if (item_no < WIN_LEN)
        begin
            step_lo = 1;
            step_hi = 1;
        end
        else if (phase == 0)
        begin
            // hold the clock so consecutive beats land at the same time
            step_lo = 0;
            step_hi = 0;
        end
        else
        begin
            case ($urandom_range(9, 0))
                0:
                begin
                    step_lo = 0;
                    step_hi = 0;
                end
                5, 6, 7:
                begin
                    step_lo = 1;
                    step_hi = 16;
                end
                8:
                begin
                    step_lo = 1;
                    step_hi = 3000;
                end
                9:
                begin
                    now_ms  = now_ms + $urandom;
                    step_lo = 1;
                    step_hi = 1;
                end
                default:
                begin
                    step_lo = 1;
                    step_hi = 1;
                end
            endcase
        end
        // flat windows sit right on a threshold or one step off it
        case ($urandom_range(3, 0))
            0:       flat_level = sb.low_thr;
            1:       flat_level = sb.low_thr - 12'd1;
            2:       flat_level = sb.high_thr;
            default: flat_level = sb.high_thr + 12'd1;
        endcase
        for (k = 0; k < WIN_LEN; k++)
        begin
            case (shape)
                WIN_LOW:  smp = (sb.low_thr == 0) ? 12'd0
                              : SAMPLE_W'($urandom_range(sb.low_thr - 1, 0));
                WIN_HIGH: smp = (sb.high_thr == 12'hFFF) ? 12'hFFF
                              : SAMPLE_W'($urandom_range(4095, sb.high_thr + 1));
                WIN_FLAT: smp = flat_level;
                default:  smp = 12'($urandom);
            endcase
            if (item_no < CORNER_COUNT)
                smp = corner_samples[item_no];
            send_sample(smp, now_ms);
            now_ms  = now_ms + $urandom_range(step_hi, step_lo);
            item_no++;
        end
    endtask

    // Wait until every expected result has been taken, then let the block
    // settle before anything touches the registers.
    task automatic drain_block();
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset once, then nine phases. Each phase writes the
    // registers while idle, streams whole windows, and drains.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int            phase;
        int            w;
        window_shape_t shape;
        int unsigned   roll;
        sb                = new();
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_REARM_LEVEL;
        cfg_data          = '0;
        sample_ch.valid   = 1'b0;
        sample_ch.sample  = '0;
        sample_ch.time_ms = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < PHASES; phase++)
        begin
            // swap the idle pattern a third of the way in; stream flat out
            // for the last third
            if (phase == 3)
            begin
                send_idle_pct = 79;
                recv_idle_pct = 29;
            end
            else if (phase == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            configure_phase(phase);
            for (w = 0; w < windows_per_phase[phase]; w++)
            begin
                // stall the result side long enough to back the block up
                // into its input while samples keep coming
                if (phase == 2 && w == 1)
                    long_hold_req = 1'b1;
                // mostly drive the detector through arm / beat cycles
                roll = $urandom_range(9, 0);
                if (roll < 7)
                    shape = sb.latched ? WIN_HIGH : WIN_LOW;
                else if (roll == 7)
                    shape = WIN_FLAT;
                else
                    shape = WIN_FULL;
                send_window(shape, phase);
            end
            sample_ch.valid <= 1'b0;
            drain_block();
        end

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
